### src/sqcf_pkg.sv
// shared types and constants for the segment quadtree cell fit unit
// controller state, command and status groups, config image, codes
// no dependencies
package sqcf_pkg;

  localparam int DW = 34;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_LAT_LOW  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LAT_HIGH = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LON_LOW  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LON_HIGH = 3'd3;

  localparam logic [30:0] LAT_LOW_RST  = 31'(-900000000);
  localparam logic [30:0] LAT_HIGH_RST = 31'(900000000);
  localparam logic [31:0] LON_LOW_RST  = 32'(-1800000000);
  localparam logic [31:0] LON_HIGH_RST = 32'(1800000000);

  localparam logic [1:0] FIT_BOTH = 2'd0;
  localparam logic [1:0] FIT_ONE  = 2'd1;
  localparam logic [1:0] FIT_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_SEL,
    S_ANC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic div_step;
    logic sel;
    logic anc_shift;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic box_ok;
    logic start_cov;
    logic end_cov;
    logic anc_equal;
  } sts_t;

  typedef struct packed {
    logic [30:0] lat_low;
    logic [30:0] lat_high;
    logic [31:0] lon_low;
    logic [31:0] lon_high;
  } cfg_t;

endpackage

### src/segment_quadtree_cell_fit_unit.sv
// top level of the segment quadtree cell fit unit: config registers, controller, datapath
// depends on sqcf_pkg, sqcf_ctrl, sqcf_dp
//
// Takes one segment beat (start and end latitude/longitude) and returns one result beat with
// the smallest quadtree cell of the 2^LOG_G grid holding both covered endpoints: its side count,
// morton code (row bits odd), row, column and a fit status. One segment is in flight at a time.
// A segment with an endpoint outside the box, or a bad box, goes from setup, the divider steps
// and the select state straight to the finish state; with both endpoints covered it first runs
// the ancestor search until both endpoints share a cell. The time is set by the four restoring
// divider lanes that produce one quotient bit per cycle and the shift loop that compares and
// halves row and column once a cycle. A finished result waits in the finish state while the
// output register stays full and stalled. The output register holds a finished
// result while the next segment is accepted. Config writes are taken at any time but belong in
// idle periods; cfg_ready is always high.
module segment_quadtree_cell_fit_unit #(
  parameter int LOG_G = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [30:0]                   in_start_lat,
  input  logic [31:0]                   in_start_lon,
  input  logic [30:0]                   in_end_lat,
  input  logic [31:0]                   in_end_lon,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [10:0]                   out_cells_per_side,
  output logic [19:0]                   out_cell_code,
  output logic [9:0]                    out_cell_row,
  output logic [9:0]                    out_cell_col,
  output logic [1:0]                    out_fit_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sqcf_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sqcf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAT_LOW:  cfg_nxt.lat_low  = cfg_data[30:0];
        REG_LAT_HIGH: cfg_nxt.lat_high = cfg_data[30:0];
        REG_LON_LOW:  cfg_nxt.lon_low  = cfg_data;
        REG_LON_HIGH: cfg_nxt.lon_high = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lat_low  <= LAT_LOW_RST;
      cfg_r.lat_high <= LAT_HIGH_RST;
      cfg_r.lon_low  <= LON_LOW_RST;
      cfg_r.lon_high <= LON_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sqcf_ctrl #(.LOG_G(LOG_G)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sqcf_dp #(.LOG_G(LOG_G)) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_start_lat       (in_start_lat),
    .in_start_lon       (in_start_lon),
    .in_end_lat         (in_end_lat),
    .in_end_lon         (in_end_lon),
    .sts                (sts),
    .out_cells_per_side (out_cells_per_side),
    .out_cell_code      (out_cell_code),
    .out_cell_row       (out_cell_row),
    .out_cell_col       (out_cell_col),
    .out_fit_status     (out_fit_status)
  );

  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_status == FIT_NONE |->
      out_cells_per_side == 11'd0 && out_cell_code == 20'd0
      && out_cell_row == 10'd0 && out_cell_col == 10'd0)
    else $error("unusable segment produced a nonzero cell");

endmodule

### src/sqcf_div.sv
// restoring divider lane, one quotient bit per step
// gives floor(num * 2^LOG_G / den), clamped to all ones when the point sits on the upper bound
// depends on sqcf_pkg
module sqcf_div #(
  parameter int LOG_G = 10
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [sqcf_pkg::DW-1:0]   num,
  input  logic [sqcf_pkg::DW-1:0]   den,
  input  logic                      at_top,
  output logic [LOG_G-1:0]          quo
);
  import sqcf_pkg::*;

  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [LOG_G-1:0] q_r;
  logic             top_r;
  logic [DW-1:0]    trial;
  logic             ge;
  logic [LOG_G:0]   q_sh;

  assign trial = {rem_r[DW-2:0], 1'b0};
  assign ge    = trial >= den_r;
  assign q_sh  = {q_r, ge};
  assign quo   = top_r ? {LOG_G{1'b1}} : q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
      top_r <= at_top;
    end else if (step) begin
      rem_r <= ge ? trial - den_r : trial;
      q_r   <= q_sh[LOG_G-1:0];
    end
  end

endmodule

### src/sqcf_ctrl.sv
// controller for the cell fit unit: sequencing of setup, division, ancestor search, output
// drives command group, reads status group and both channel handshakes
// depends on sqcf_pkg
module sqcf_ctrl #(
  parameter int LOG_G = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sqcf_pkg::sts_t sts,
  output sqcf_pkg::cmd_t cmd
);
  import sqcf_pkg::*;

  localparam int CW = $clog2(LOG_G + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          div_last;
  logic          slot_free;

  assign div_last  = cnt_r == CW'(LOG_G - 1);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_DIV;
      S_DIV:   if (div_last) state_nxt = S_SEL;
      S_SEL: begin
        if (sts.box_ok && sts.start_cov && sts.end_cov) state_nxt = S_ANC;
        else state_nxt = S_FIN;
      end
      S_ANC:   if (sts.anc_equal) state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      S_SEL:   cmd.sel = 1'b1;
      S_ANC:   cmd.anc_shift = !sts.anc_equal;
      S_FIN:   cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_setup : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_SETUP)
    else $error("accepted beat did not start setup");

  a_div_len : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_last |=> state_r == S_SEL)
    else $error("division did not end after LOG_G steps");

  a_fin_out : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented from an empty output slot");

endmodule

### src/sqcf_dp.sv
// datapath for the cell fit unit: input latch, coverage tests, four divider lanes,
// ancestor shift registers, morton interleave and output register
// depends on sqcf_pkg and sqcf_div
module sqcf_dp #(
  parameter int LOG_G = 10
) (
  input  logic           clk,
  input  sqcf_pkg::cmd_t cmd,
  input  sqcf_pkg::cfg_t cfg,
  input  logic [30:0]    in_start_lat,
  input  logic [31:0]    in_start_lon,
  input  logic [30:0]    in_end_lat,
  input  logic [31:0]    in_end_lon,
  output sqcf_pkg::sts_t sts,
  output logic [10:0]    out_cells_per_side,
  output logic [19:0]    out_cell_code,
  output logic [9:0]     out_cell_row,
  output logic [9:0]     out_cell_col,
  output logic [1:0]     out_fit_status
);
  import sqcf_pkg::*;

  logic [30:0] slat_r, elat_r;
  logic [31:0] slon_r, elon_r;

  logic [DW-1:0] x_slat, x_elat, x_slon, x_elon;
  logic [DW-1:0] x_lat_lo, x_lat_hi, x_lon_lo, x_lon_hi;
  logic [DW-1:0] d_slat, d_elat, d_slon, d_elon, den_lat, den_lon;
  logic          box_ok, s_cov, e_cov;
  logic          box_ok_r, sc_r, ec_r;

  logic [LOG_G-1:0] q_sr, q_sc, q_er, q_ec;
  logic [LOG_G-1:0] ar0_r, ac0_r, ar1_r, ac1_r;
  logic [LOG_G:0]   side_r;

  logic [2*LOG_G-1:0] code;
  logic [LOG_G+11:0]  side_ext;
  logic [2*LOG_G+19:0] code_ext;
  logic [LOG_G+9:0]   row_ext, col_ext;
  logic               usable;
  logic [1:0]         fit;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      slat_r <= in_start_lat;
      slon_r <= in_start_lon;
      elat_r <= in_end_lat;
      elon_r <= in_end_lon;
    end
  end

  assign x_slat   = {{(DW-31){slat_r[30]}}, slat_r};
  assign x_elat   = {{(DW-31){elat_r[30]}}, elat_r};
  assign x_slon   = {{(DW-32){slon_r[31]}}, slon_r};
  assign x_elon   = {{(DW-32){elon_r[31]}}, elon_r};
  assign x_lat_lo = {{(DW-31){cfg.lat_low[30]}}, cfg.lat_low};
  assign x_lat_hi = {{(DW-31){cfg.lat_high[30]}}, cfg.lat_high};
  assign x_lon_lo = {{(DW-32){cfg.lon_low[31]}}, cfg.lon_low};
  assign x_lon_hi = {{(DW-32){cfg.lon_high[31]}}, cfg.lon_high};

  assign d_slat  = x_slat - x_lat_lo;
  assign d_elat  = x_elat - x_lat_lo;
  assign d_slon  = x_slon - x_lon_lo;
  assign d_elon  = x_elon - x_lon_lo;
  assign den_lat = x_lat_hi - x_lat_lo;
  assign den_lon = x_lon_hi - x_lon_lo;

  assign box_ok = $signed(cfg.lat_high) > $signed(cfg.lat_low)
               && $signed(cfg.lon_high) > $signed(cfg.lon_low);
  assign s_cov  = $signed(slat_r) >= $signed(cfg.lat_low)
               && $signed(slat_r) <= $signed(cfg.lat_high)
               && $signed(slon_r) >= $signed(cfg.lon_low)
               && $signed(slon_r) <= $signed(cfg.lon_high);
  assign e_cov  = $signed(elat_r) >= $signed(cfg.lat_low)
               && $signed(elat_r) <= $signed(cfg.lat_high)
               && $signed(elon_r) >= $signed(cfg.lon_low)
               && $signed(elon_r) <= $signed(cfg.lon_high);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      box_ok_r <= box_ok;
      sc_r     <= s_cov;
      ec_r     <= e_cov;
    end
  end

  sqcf_div #(.LOG_G(LOG_G)) u_div_sr (
    .clk(clk), .load(cmd.setup), .step(cmd.div_step),
    .num(d_slat), .den(den_lat), .at_top(slat_r == cfg.lat_high), .quo(q_sr)
  );
  sqcf_div #(.LOG_G(LOG_G)) u_div_sc (
    .clk(clk), .load(cmd.setup), .step(cmd.div_step),
    .num(d_slon), .den(den_lon), .at_top(slon_r == cfg.lon_high), .quo(q_sc)
  );
  sqcf_div #(.LOG_G(LOG_G)) u_div_er (
    .clk(clk), .load(cmd.setup), .step(cmd.div_step),
    .num(d_elat), .den(den_lat), .at_top(elat_r == cfg.lat_high), .quo(q_er)
  );
  sqcf_div #(.LOG_G(LOG_G)) u_div_ec (
    .clk(clk), .load(cmd.setup), .step(cmd.div_step),
    .num(d_elon), .den(den_lon), .at_top(elon_r == cfg.lon_high), .quo(q_ec)
  );

  // slot 0 carries the reported cell, slot 1 the end point for the ancestor search
  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      ar0_r  <= sc_r ? q_sr : q_er;
      ac0_r  <= sc_r ? q_sc : q_ec;
      ar1_r  <= q_er;
      ac1_r  <= q_ec;
      side_r <= {1'b1, {LOG_G{1'b0}}};
    end else if (cmd.anc_shift) begin
      ar0_r  <= ar0_r >> 1;
      ac0_r  <= ac0_r >> 1;
      ar1_r  <= ar1_r >> 1;
      ac1_r  <= ac1_r >> 1;
      side_r <= side_r >> 1;
    end
  end

  assign sts.box_ok    = box_ok_r;
  assign sts.start_cov = sc_r;
  assign sts.end_cov   = ec_r;
  assign sts.anc_equal = (ar0_r == ar1_r) && (ac0_r == ac1_r);

  always_comb begin
    code = '0;
    for (int i = 0; i < LOG_G; i++) begin
      code[2*i+1] = ar0_r[i];
      code[2*i]   = ac0_r[i];
    end
  end

  assign usable   = box_ok_r && (sc_r || ec_r);
  assign fit      = !usable ? FIT_NONE : ((sc_r && ec_r) ? FIT_BOTH : FIT_ONE);
  assign side_ext = {11'b0, side_r};
  assign code_ext = {20'b0, code};
  assign row_ext  = {10'b0, ar0_r};
  assign col_ext  = {10'b0, ac0_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fit_status     <= fit;
      out_cells_per_side <= usable ? side_ext[10:0] : 11'd0;
      out_cell_code      <= usable ? code_ext[19:0] : 20'd0;
      out_cell_row       <= usable ? row_ext[9:0] : 10'd0;
      out_cell_col       <= usable ? col_ext[9:0] : 10'd0;
    end
  end

endmodule

### tb/sv/cell_fit_checker.sv
// result checker for the segment quadtree cell fit unit: predicts each segment's fitting cell
// and compares it against the result beats
// depends on sqcf_pkg
module cell_fit_checker #(
  parameter int LOG_G = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [30:0]                 in_start_lat,
  input  logic [31:0]                 in_start_lon,
  input  logic [30:0]                 in_end_lat,
  input  logic [31:0]                 in_end_lon,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [10:0]                 out_cells_per_side,
  input  logic [19:0]                 out_cell_code,
  input  logic [9:0]                  out_cell_row,
  input  logic [9:0]                  out_cell_col,
  input  logic [1:0]                  out_fit_status,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [sqcf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          fit_failures,
  output int                          cells_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sqcf_pkg::*;

  localparam logic [63:0] GRID = 64'd1 << LOG_G;

  typedef struct packed {
    logic [10:0] side;
    logic [19:0] code;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [1:0]  status;
  } cell_fit_t;

  longint box_lat_lo, box_lat_hi, box_lon_lo, box_lon_hi;
  cell_fit_t expected_cells[$];

  function automatic logic [63:0] interleave(logic [63:0] r, logic [63:0] c);
    logic [63:0] z;
    z = '0;
    for (int i = 0; i < 16; i++) begin
      z[2*i+1] = r[i];
      z[2*i]   = c[i];
    end
    return z;
  endfunction

  function automatic logic [63:0] grid_index(longint v, longint lo, longint hi);
    logic [63:0] num, den, q;
    num = 64'(v - lo) << LOG_G;
    den = 64'(hi - lo);
    q = num / den;
    return (q >= GRID) ? GRID - 1 : q;
  endfunction

  function automatic logic covers_point(longint lat, longint lon);
    return lat >= box_lat_lo && lat <= box_lat_hi && lon >= box_lon_lo && lon <= box_lon_hi;
  endfunction

  function automatic cell_fit_t fit_cell(longint slat, longint slon, longint elat, longint elon);
    cell_fit_t res;
    logic [63:0] r0, c0, r1, c1, side, row, col, code;
    logic sc, ec;
    res = '0;
    res.status = FIT_NONE;
    if (box_lat_hi > box_lat_lo && box_lon_hi > box_lon_lo) begin
      sc = covers_point(slat, slon);
      ec = covers_point(elat, elon);
      if (sc || ec) begin
        r0 = sc ? grid_index(slat, box_lat_lo, box_lat_hi) : '0;
        c0 = sc ? grid_index(slon, box_lon_lo, box_lon_hi) : '0;
        r1 = ec ? grid_index(elat, box_lat_lo, box_lat_hi) : '0;
        c1 = ec ? grid_index(elon, box_lon_lo, box_lon_hi) : '0;
        side = GRID;
        if (sc && ec) begin
          while (interleave(r0, c0) != interleave(r1, c1)) begin
            r0 >>= 1;
            c0 >>= 1;
            r1 >>= 1;
            c1 >>= 1;
            side >>= 1;
          end
          row = r0;
          col = c0;
          res.status = FIT_BOTH;
        end else if (sc) begin
          row = r0;
          col = c0;
          res.status = FIT_ONE;
        end else begin
          row = r1;
          col = c1;
          res.status = FIT_ONE;
        end
        code = interleave(row, col);
        res.side = side[10:0];
        res.code = code[19:0];
        res.row = row[9:0];
        res.col = col[9:0];
      end
    end
    return res;
  endfunction

  function automatic string show(cell_fit_t c);
    return $sformatf("side %0d code 0x%05h row %0d col %0d status %0d",
                     c.side, c.code, c.row, c.col, c.status);
  endfunction

  task automatic report_failure(string msg);
    fit_failures++;
    if (fit_failures <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin
    cell_fit_t got, want;
    if (!rst_n) begin
      box_lat_lo = longint'($signed(LAT_LOW_RST));
      box_lat_hi = longint'($signed(LAT_HIGH_RST));
      box_lon_lo = longint'($signed(LON_LOW_RST));
      box_lon_hi = longint'($signed(LON_HIGH_RST));
      expected_cells.delete();
      fit_failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LAT_LOW:  box_lat_lo = longint'($signed(cfg_data[30:0]));
          REG_LAT_HIGH: box_lat_hi = longint'($signed(cfg_data[30:0]));
          REG_LON_LOW:  box_lon_lo = longint'($signed(cfg_data));
          REG_LON_HIGH: box_lon_hi = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_cells.push_back(fit_cell(longint'($signed(in_start_lat)),
                                          longint'($signed(in_start_lon)),
                                          longint'($signed(in_end_lat)),
                                          longint'($signed(in_end_lon))));
      end
      if (out_valid && !out_stall) begin
        got = '{out_cells_per_side, out_cell_code, out_cell_row, out_cell_col, out_fit_status};
        if (expected_cells.size() == 0) begin
          report_failure({"unexpected result beat: ", show(got)});
        end else begin
          want = expected_cells.pop_front();
          if (got.side !== want.side || got.code !== want.code || got.row !== want.row ||
              got.col !== want.col || got.status !== want.status) begin
            report_failure({"cell mismatch: expected ", show(want), ", got ", show(got)});
          end
        end
      end
    end
    cells_pending = expected_cells.size();
  end

endmodule

### tb/sv/tb.sv
// top of the segment quadtree cell fit testbench: clock, reset, segment, config and result
// stimulus with stalls, and the verdict
// depends on sqcf_pkg, cell_fit_checker and the unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sqcf_pkg::*;

  localparam int LOG_G = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_IW-1:0] REG_SPARE = 3'd4;

  localparam longint LAT_FIELD_MIN = -64'sd1073741824;
  localparam longint LAT_FIELD_MAX = 64'sd1073741823;
  localparam longint LON_FIELD_MIN = -64'sd2147483648;
  localparam longint LON_FIELD_MAX = 64'sd2147483647;
  localparam longint LAT_RST_LO = longint'($signed(LAT_LOW_RST));
  localparam longint LAT_RST_HI = longint'($signed(LAT_HIGH_RST));
  localparam longint LON_RST_LO = longint'($signed(LON_LOW_RST));
  localparam longint LON_RST_HI = longint'($signed(LON_HIGH_RST));

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [30:0]       in_start_lat;
  logic [31:0]       in_start_lon;
  logic [30:0]       in_end_lat;
  logic [31:0]       in_end_lon;
  logic              out_valid;
  logic              out_stall;
  logic [10:0]       out_cells_per_side;
  logic [19:0]       out_cell_code;
  logic [9:0]        out_cell_row;
  logic [9:0]        out_cell_col;
  logic [1:0]        out_fit_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0]       cfg_data;

  int     fit_failures;
  int     cells_pending;
  int     send_gap_pct;
  int     recv_stall_pct;
  int     quiet_cycles;
  logic   hold_req;
  longint cur_lat_lo, cur_lat_hi, cur_lon_lo, cur_lon_hi;

  segment_quadtree_cell_fit_unit #(
    .LOG_G(LOG_G)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_lat      (in_start_lat),
    .in_start_lon      (in_start_lon),
    .in_end_lat        (in_end_lat),
    .in_end_lon        (in_end_lon),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cells_per_side(out_cells_per_side),
    .out_cell_code     (out_cell_code),
    .out_cell_row      (out_cell_row),
    .out_cell_col      (out_cell_col),
    .out_fit_status    (out_fit_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  cell_fit_checker #(
    .LOG_G(LOG_G)
  ) fit_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_lat      (in_start_lat),
    .in_start_lon      (in_start_lon),
    .in_end_lat        (in_end_lat),
    .in_end_lon        (in_end_lon),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cells_per_side(out_cells_per_side),
    .out_cell_code     (out_cell_code),
    .out_cell_row      (out_cell_row),
    .out_cell_col      (out_cell_col),
    .out_fit_status    (out_fit_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fit_failures      (fit_failures),
    .cells_pending     (cells_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_quadtree_cell_fit_unit regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_segment(longint slat, longint slon, longint elat, longint elon);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_lat <= 31'(slat);
    in_start_lon <= 32'(slon);
    in_end_lat <= 31'(elat);
    in_end_lon <= 32'(elon);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 32'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_box(longint lat_lo, longint lat_hi, longint lon_lo, longint lon_hi);
    write_reg(REG_LAT_LOW, lat_lo);
    write_reg(REG_LAT_HIGH, lat_hi);
    write_reg(REG_LON_LOW, lon_lo);
    write_reg(REG_LON_HIGH, lon_hi);
    cfg_valid <= 1'b0;
    cur_lat_lo = longint'($signed(31'(lat_lo)));
    cur_lat_hi = longint'($signed(31'(lat_hi)));
    cur_lon_lo = longint'($signed(32'(lon_lo)));
    cur_lon_hi = longint'($signed(32'(lon_hi)));
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    while (cells_pending != 0) @(negedge clk);
  endtask

  function automatic longint pick_coord(longint lo, longint hi);
    longint span;
    int pick;
    logic [63:0] draw;
    span = hi - lo;
    pick = $urandom_range(99);
    draw = {$urandom, $urandom};
    if (pick < 5) return longint'(draw);
    if (pick < 8) return lo - $urandom_range(1, 1000);
    if (pick < 11) return hi + $urandom_range(1, 1000);
    if (pick < 15) return pick[0] ? lo : hi;
    if (span <= 0) return lo + $urandom_range(0, 1000) - 500;
    return lo + longint'(draw % 64'(span + 1));
  endfunction

  function automatic longint near_coord(longint v, longint lo, longint hi);
    longint reach;
    logic [63:0] draw;
    reach = (hi - lo) >>> $urandom_range(0, 16);
    if (reach < 1) reach = 1;
    draw = {$urandom, $urandom};
    return v + longint'(draw % 64'(2 * reach + 1)) - reach;
  endfunction

  task automatic run_random(int count);
    longint slat, slon, elat, elon;
    repeat (count) begin
      slat = pick_coord(cur_lat_lo, cur_lat_hi);
      slon = pick_coord(cur_lon_lo, cur_lon_hi);
      if ($urandom_range(99) < 60) begin
        elat = near_coord(slat, cur_lat_lo, cur_lat_hi);
        elon = near_coord(slon, cur_lon_lo, cur_lon_hi);
      end else begin
        elat = pick_coord(cur_lat_lo, cur_lat_hi);
        elon = pick_coord(cur_lon_lo, cur_lon_hi);
      end
      send_segment(slat, slon, elat, elon);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_lat = '0;
    in_start_lon = '0;
    in_end_lat = '0;
    in_end_lon = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LAT_LOW;
    cfg_data = '0;
    hold_req = 1'b0;
    send_gap_pct = 7;
    recv_stall_pct = 56;
    cur_lat_lo = LAT_RST_LO;
    cur_lat_hi = LAT_RST_HI;
    cur_lon_lo = LON_RST_LO;
    cur_lon_hi = LON_RST_HI;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_segment(LAT_RST_LO, LON_RST_LO, LAT_RST_LO, LON_RST_LO);
    send_segment(LAT_RST_HI, LON_RST_HI, LAT_RST_HI, LON_RST_HI);
    send_segment(LAT_RST_LO, LON_RST_LO, LAT_RST_HI, LON_RST_HI);
    send_segment(LAT_RST_HI, LON_RST_LO, LAT_RST_LO, LON_RST_HI);
    send_segment(0, 0, 1, 1);
    send_segment(-1, -1, 0, 0);
    send_segment(10000000, 20000000, 10000100, 20000100);
    send_segment(LAT_RST_LO - 1, 0, 100, 200);
    send_segment(5, 7, LAT_RST_HI + 1, 0);
    send_segment(0, LON_RST_LO - 1, 0, LON_RST_HI + 1);
    send_segment(LAT_FIELD_MIN, LON_FIELD_MIN, LAT_FIELD_MAX, LON_FIELD_MAX);
    send_segment(0, LON_FIELD_MAX, 123456789, -987654321);
    run_random(200);

    // fill the unit while results are held back
    hold_req = 1'b1;
    run_random(24);
    settle_results();

    write_box(400000000, 400000700, -5000, 123456);
    run_random(200);
    settle_results();

    send_gap_pct = 56;
    recv_stall_pct = 7;
    write_box(LAT_FIELD_MIN, LAT_FIELD_MAX, LON_FIELD_MIN, LON_FIELD_MAX);
    send_segment(LAT_FIELD_MIN, LON_FIELD_MIN, LAT_FIELD_MAX, LON_FIELD_MAX);
    send_segment(LAT_FIELD_MAX, LON_FIELD_MAX, LAT_FIELD_MAX, LON_FIELD_MAX);
    send_segment(LAT_FIELD_MIN, LON_FIELD_MAX, LAT_FIELD_MAX, LON_FIELD_MIN);
    send_segment(0, 0, -1, -1);
    run_random(150);
    settle_results();

    write_box(0, 1, -1, 0);
    send_segment(0, -1, 1, 0);
    send_segment(1, 0, 1, 0);
    run_random(100);
    settle_results();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_box(5000, 5000, -1000000, 1000000);
    send_segment(5000, 0, 5000, 0);
    send_segment(4999, 0, 5001, 1);
    run_random(30);
    settle_results();

    write_box(-1000, 1000, 10, -10);
    write_reg(REG_SPARE, 32'h7fff_ffff);
    cfg_valid <= 1'b0;
    send_segment(0, 0, 0, 0);
    run_random(30);
    settle_results();

    write_box(LAT_RST_LO, LAT_RST_HI, LON_RST_LO, LON_RST_HI);
    run_random(300);
    settle_results();

    repeat (2 * LOG_G + 8) @(negedge clk);
    if (fit_failures == 0 && cells_pending == 0) begin
      $display("segment_quadtree_cell_fit_unit regression: pass");
    end else begin
      $display("segment_quadtree_cell_fit_unit regression: fail");
    end
    $finish;
  end

endmodule
